### hdl/process_entry_queue_manager_unit_macros.svh
// assertion macros for the entry queue manager checker
// expects signals named clock and reset in the scope of use
`ifndef PROCESS_ENTRY_QUEUE_MANAGER_UNIT_MACROS_SVH
`define PROCESS_ENTRY_QUEUE_MANAGER_UNIT_MACROS_SVH

// property checked outside reset
`define PEQM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("peqm check failed");

// property that also covers the reset cycles
`define PEQM_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("peqm check failed");

`endif

### hdl/peqm_pkg.sv
// shared constants, types and functions of the entry queue manager
// no dependencies
package peqm_pkg;

   localparam int NUM_ENTRIES = 32;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int LINK_W      = $clog2(NUM_ENTRIES + 1);
   localparam int CNT_W       = LINK_W;
   localparam int NUM_ARR     = 6;

   localparam int FUNC_W  = 4;
   localparam int TAIL_W  = 6;
   localparam int ENTRY_W = 5;
   localparam int RES_W   = 6;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 16;

   localparam logic [LINK_W-1:0] NONE = LINK_W'(NUM_ENTRIES);

   localparam logic [FUNC_W-1:0] FN_ALLOC   = 4'd0;
   localparam logic [FUNC_W-1:0] FN_FREE    = 4'd1;
   localparam logic [FUNC_W-1:0] FN_ENQ     = 4'd2;
   localparam logic [FUNC_W-1:0] FN_DEQ     = 4'd3;
   localparam logic [FUNC_W-1:0] FN_REMOVE  = 4'd4;
   localparam logic [FUNC_W-1:0] FN_PEEK    = 4'd5;
   localparam logic [FUNC_W-1:0] FN_ADD_CH  = 4'd6;
   localparam logic [FUNC_W-1:0] FN_REM_CH  = 4'd7;
   localparam logic [FUNC_W-1:0] FN_DETACH  = 4'd8;

   typedef enum logic [2:0] {
      ARR_NEXT   = 3'd0,
      ARR_PREV   = 3'd1,
      ARR_PARENT = 3'd2,
      ARR_FCHILD = 3'd3,
      ARR_NSIB   = 3'd4,
      ARR_PSIB   = 3'd5
   } arr_type;

   localparam logic [NUM_ARR-1:0] MASK_NEXT   = 6'b000001;
   localparam logic [NUM_ARR-1:0] MASK_PREV   = 6'b000010;
   localparam logic [NUM_ARR-1:0] MASK_PARENT = 6'b000100;
   localparam logic [NUM_ARR-1:0] MASK_FCHILD = 6'b001000;
   localparam logic [NUM_ARR-1:0] MASK_NSIB   = 6'b010000;
   localparam logic [NUM_ARR-1:0] MASK_PSIB   = 6'b100000;

   typedef enum logic [3:0] {
      SRC_NONE = 4'd0,
      SRC_TL   = 4'd1,
      SRC_FT   = 4'd2,
      SRC_P    = 4'd3,
      SRC_PAR  = 4'd4,
      SRC_A    = 4'd5,
      SRC_B    = 4'd6,
      SRC_C    = 4'd7,
      SRC_D    = 4'd8,
      SRC_RES  = 4'd9
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_A    = 3'd1,
      DST_B    = 3'd2,
      DST_C    = 3'd3,
      DST_D    = 3'd4,
      DST_RES  = 3'd5,
      DST_TL   = 3'd6,
      DST_FT   = 3'd7
   } dst_type;

   typedef struct packed {
      logic               load;
      logic               done;
      logic               rd_en;
      arr_type            rd_arr;
      src_type            rd_addr;
      dst_type            rd_dst;
      logic [NUM_ARR-1:0] wr_mask;
      src_type            wr_addr;
      src_type            wr_data;
      logic               mv_en;
      dst_type            mv_dst;
      src_type            mv_src;
      logic               cnt_clr;
      logic               cnt_inc;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              p_ok;
      logic              par_ok;
      logic              tl_none;
      logic              ft_none;
      logic              a_none;
      logic              c_none;
      logic              a_eq_p;
      logic              a_eq_tl;
      logic              a_eq_ft;
      logic              b_eq_p;
      logic              d_eq_p;
      logic              p_eq_tl;
      logic              cnt_end;
      logic              rsp_busy;
   } status_type;

   // link value of an entry that was never written since reset
   function automatic logic [LINK_W-1:0] reset_link(arr_type arr, logic [IDX_W-1:0] idx);
      logic [LINK_W-1:0] val;
      case (arr)
         ARR_NEXT: begin
            val = (idx == IDX_W'(NUM_ENTRIES - 1)) ? '0 : LINK_W'(idx) + LINK_W'(1);
         end
         ARR_PREV: begin
            val = (idx == '0) ? LINK_W'(NUM_ENTRIES - 1) : LINK_W'(idx) - LINK_W'(1);
         end
         default: begin
            val = NONE;
         end
      endcase
      return val;
   endfunction

endpackage

### hdl/peqm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module peqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/peqm_ctrl.sv
// sequencer of the entry queue manager: one step of a request per state
// depends on peqm_pkg
module peqm_ctrl import peqm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int ST_W = 51;

   typedef enum logic [ST_W-1:0] {
      ST_IDLE = (ST_W'(1) << 0),
      ST_DEC  = (ST_W'(1) << 1),
      ST_TH0  = (ST_W'(1) << 2),
      ST_TH1  = (ST_W'(1) << 3),
      ST_TH2  = (ST_W'(1) << 4),
      ST_TH3  = (ST_W'(1) << 5),
      ST_TH4  = (ST_W'(1) << 6),
      ST_TH5  = (ST_W'(1) << 7),
      ST_TH6  = (ST_W'(1) << 8),
      ST_CLR  = (ST_W'(1) << 9),
      ST_AP0  = (ST_W'(1) << 10),
      ST_AP1  = (ST_W'(1) << 11),
      ST_AP2  = (ST_W'(1) << 12),
      ST_AP3  = (ST_W'(1) << 13),
      ST_AP4  = (ST_W'(1) << 14),
      ST_AP5  = (ST_W'(1) << 15),
      ST_RN0  = (ST_W'(1) << 16),
      ST_RN1  = (ST_W'(1) << 17),
      ST_RN2  = (ST_W'(1) << 18),
      ST_RN3  = (ST_W'(1) << 19),
      ST_RN4  = (ST_W'(1) << 20),
      ST_RN5  = (ST_W'(1) << 21),
      ST_RN6  = (ST_W'(1) << 22),
      ST_RN7  = (ST_W'(1) << 23),
      ST_PK0  = (ST_W'(1) << 24),
      ST_PK1  = (ST_W'(1) << 25),
      ST_AC0  = (ST_W'(1) << 26),
      ST_AC1  = (ST_W'(1) << 27),
      ST_AC2  = (ST_W'(1) << 28),
      ST_AC3  = (ST_W'(1) << 29),
      ST_AC4  = (ST_W'(1) << 30),
      ST_AC5  = (ST_W'(1) << 31),
      ST_AC6  = (ST_W'(1) << 32),
      ST_RC0  = (ST_W'(1) << 33),
      ST_RC1  = (ST_W'(1) << 34),
      ST_RC2  = (ST_W'(1) << 35),
      ST_RC3  = (ST_W'(1) << 36),
      ST_RC4  = (ST_W'(1) << 37),
      ST_RC5  = (ST_W'(1) << 38),
      ST_RC6  = (ST_W'(1) << 39),
      ST_DC0  = (ST_W'(1) << 40),
      ST_DC1  = (ST_W'(1) << 41),
      ST_DC2  = (ST_W'(1) << 42),
      ST_DC3  = (ST_W'(1) << 43),
      ST_DC4  = (ST_W'(1) << 44),
      ST_DC5  = (ST_W'(1) << 45),
      ST_DC6  = (ST_W'(1) << 46),
      ST_DC7  = (ST_W'(1) << 47),
      ST_DC8  = (ST_W'(1) << 48),
      ST_DC9  = (ST_W'(1) << 49),
      ST_FIN  = (ST_W'(1) << 50)
   } state_type;

   state_type state_ff, state_in;
   logic      qsel_ff, qsel_in;    // 1: free list, 0: caller queue

   src_type q_src;
   dst_type q_dst;
   logic    q_none;
   logic    a_eq_q;

   assign q_src  = qsel_ff ? SRC_FT : SRC_TL;
   assign q_dst  = qsel_ff ? DST_FT : DST_TL;
   assign q_none = qsel_ff ? status.ft_none : status.tl_none;
   assign a_eq_q = qsel_ff ? status.a_eq_ft : status.a_eq_tl;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      qsel_in  = qsel_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            case (status.func)
               FN_ALLOC: begin
                  qsel_in  = 1'b1;
                  state_in = ST_TH0;
               end
               FN_FREE: begin
                  qsel_in  = 1'b1;
                  state_in = ST_AP0;
               end
               FN_ENQ: begin
                  qsel_in  = 1'b0;
                  state_in = ST_AP0;
               end
               FN_DEQ: begin
                  qsel_in  = 1'b0;
                  state_in = ST_TH0;
               end
               FN_REMOVE: state_in = ST_RN0;
               FN_PEEK:   state_in = ST_PK0;
               FN_ADD_CH: state_in = ST_AC0;
               FN_REM_CH: state_in = ST_RC0;
               FN_DETACH: state_in = ST_DC0;
               default:   state_in = ST_FIN;
            endcase
         end
         // take the head of a queue
         ST_TH0: begin
            if (q_none) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_NEXT;
               cmd.rd_addr = q_src;
               cmd.rd_dst  = DST_A;
               state_in    = ST_TH1;
            end
         end
         ST_TH1: state_in = ST_TH2;
         ST_TH2: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_arr  = ARR_NEXT;
            cmd.rd_addr = SRC_A;
            cmd.rd_dst  = DST_B;
            state_in    = ST_TH3;
         end
         ST_TH3: state_in = ST_TH4;
         ST_TH4: begin
            cmd.wr_mask = MASK_NEXT;
            cmd.wr_addr = q_src;
            cmd.wr_data = SRC_B;
            state_in    = ST_TH5;
         end
         ST_TH5: begin
            cmd.wr_mask = MASK_PREV;
            cmd.wr_addr = SRC_B;
            cmd.wr_data = q_src;
            if (a_eq_q) begin
               cmd.mv_en  = 1'b1;
               cmd.mv_dst = q_dst;
               cmd.mv_src = SRC_NONE;
            end
            state_in = ST_TH6;
         end
         ST_TH6: begin
            cmd.mv_en  = 1'b1;
            cmd.mv_dst = DST_RES;
            cmd.mv_src = SRC_A;
            state_in   = (status.func == FN_ALLOC) ? ST_CLR : ST_FIN;
         end
         ST_CLR: begin
            cmd.wr_mask = '1;
            cmd.wr_addr = SRC_RES;
            cmd.wr_data = SRC_NONE;
            state_in    = ST_FIN;
         end
         // append an entry to a queue
         ST_AP0: begin
            if (!status.p_ok) begin
               state_in = ST_FIN;
            end else if (q_none) begin
               cmd.wr_mask = MASK_NEXT | MASK_PREV;
               cmd.wr_addr = SRC_P;
               cmd.wr_data = SRC_P;
               cmd.mv_en   = 1'b1;
               cmd.mv_dst  = q_dst;
               cmd.mv_src  = SRC_P;
               state_in    = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_NEXT;
               cmd.rd_addr = q_src;
               cmd.rd_dst  = DST_A;
               state_in    = ST_AP1;
            end
         end
         ST_AP1: state_in = ST_AP2;
         ST_AP2: begin
            cmd.wr_mask = MASK_NEXT;
            cmd.wr_addr = SRC_P;
            cmd.wr_data = SRC_A;
            state_in    = ST_AP3;
         end
         ST_AP3: begin
            cmd.wr_mask = MASK_NEXT;
            cmd.wr_addr = q_src;
            cmd.wr_data = SRC_P;
            state_in    = ST_AP4;
         end
         ST_AP4: begin
            cmd.wr_mask = MASK_PREV;
            cmd.wr_addr = SRC_P;
            cmd.wr_data = q_src;
            state_in    = ST_AP5;
         end
         ST_AP5: begin
            cmd.wr_mask = MASK_PREV;
            cmd.wr_addr = SRC_A;
            cmd.wr_data = SRC_P;
            cmd.mv_en   = 1'b1;
            cmd.mv_dst  = q_dst;
            cmd.mv_src  = SRC_P;
            state_in    = ST_FIN;
         end
         // walk the caller queue looking for the named entry
         ST_RN0: begin
            if (!status.p_ok || status.tl_none) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_NEXT;
               cmd.rd_addr = SRC_TL;
               cmd.rd_dst  = DST_A;
               cmd.cnt_clr = 1'b1;
               state_in    = ST_RN1;
            end
         end
         ST_RN1: state_in = ST_RN2;
         ST_RN2: begin
            if (status.cnt_end || status.a_none) begin
               state_in = ST_FIN;
            end else if (status.a_eq_p) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_NEXT;
               cmd.rd_addr = SRC_P;
               cmd.rd_dst  = DST_B;
               state_in    = ST_RN3;
            end else if (status.a_eq_tl) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_NEXT;
               cmd.rd_addr = SRC_A;
               cmd.rd_dst  = DST_A;
               cmd.cnt_inc = 1'b1;
               state_in    = ST_RN1;
            end
         end
         ST_RN3: state_in = ST_RN4;
         ST_RN4: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_arr  = ARR_PREV;
            cmd.rd_addr = SRC_P;
            cmd.rd_dst  = DST_C;
            state_in    = ST_RN5;
         end
         ST_RN5: state_in = ST_RN6;
         ST_RN6: begin
            if (status.p_eq_tl) begin
               cmd.mv_en  = 1'b1;
               cmd.mv_dst = DST_TL;
               cmd.mv_src = status.b_eq_p ? SRC_NONE : SRC_C;
            end
            if (!status.b_eq_p) begin
               cmd.wr_mask = MASK_PREV;
               cmd.wr_addr = SRC_B;
               cmd.wr_data = SRC_C;
            end
            state_in = ST_RN7;
         end
         ST_RN7: begin
            if (!status.b_eq_p) begin
               cmd.wr_mask = MASK_NEXT;
               cmd.wr_addr = SRC_C;
               cmd.wr_data = SRC_B;
            end
            cmd.mv_en  = 1'b1;
            cmd.mv_dst = DST_RES;
            cmd.mv_src = SRC_P;
            state_in   = ST_FIN;
         end
         ST_PK0: begin
            if (status.tl_none) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_NEXT;
               cmd.rd_addr = SRC_TL;
               cmd.rd_dst  = DST_RES;
               state_in    = ST_PK1;
            end
         end
         ST_PK1: state_in = ST_FIN;
         // add child in front of the parent's child list
         ST_AC0: begin
            if (!(status.p_ok && status.par_ok)) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_FCHILD;
               cmd.rd_addr = SRC_PAR;
               cmd.rd_dst  = DST_A;
               state_in    = ST_AC1;
            end
         end
         ST_AC1: state_in = ST_AC2;
         ST_AC2: begin
            cmd.wr_mask = MASK_NSIB;
            cmd.wr_addr = SRC_P;
            cmd.wr_data = SRC_A;
            state_in    = ST_AC3;
         end
         ST_AC3: begin
            cmd.wr_mask = MASK_PSIB;
            cmd.wr_addr = SRC_P;
            cmd.wr_data = SRC_NONE;
            state_in    = ST_AC4;
         end
         ST_AC4: begin
            cmd.wr_mask = MASK_PSIB;
            cmd.wr_addr = SRC_A;
            cmd.wr_data = SRC_P;
            state_in    = ST_AC5;
         end
         ST_AC5: begin
            cmd.wr_mask = MASK_FCHILD;
            cmd.wr_addr = SRC_PAR;
            cmd.wr_data = SRC_P;
            state_in    = ST_AC6;
         end
         ST_AC6: begin
            cmd.wr_mask = MASK_PARENT;
            cmd.wr_addr = SRC_P;
            cmd.wr_data = SRC_PAR;
            state_in    = ST_FIN;
         end
         // remove first child
         ST_RC0: begin
            if (!status.par_ok) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_FCHILD;
               cmd.rd_addr = SRC_PAR;
               cmd.rd_dst  = DST_C;
               state_in    = ST_RC1;
            end
         end
         ST_RC1: state_in = ST_RC2;
         ST_RC2: begin
            if (status.c_none) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_NSIB;
               cmd.rd_addr = SRC_C;
               cmd.rd_dst  = DST_B;
               state_in    = ST_RC3;
            end
         end
         ST_RC3: state_in = ST_RC4;
         ST_RC4: begin
            cmd.wr_mask = MASK_FCHILD;
            cmd.wr_addr = SRC_PAR;
            cmd.wr_data = SRC_B;
            state_in    = ST_RC5;
         end
         ST_RC5: begin
            cmd.wr_mask = MASK_PSIB;
            cmd.wr_addr = SRC_B;
            cmd.wr_data = SRC_NONE;
            state_in    = ST_RC6;
         end
         ST_RC6: begin
            cmd.wr_mask = MASK_PARENT | MASK_NSIB | MASK_PSIB;
            cmd.wr_addr = SRC_C;
            cmd.wr_data = SRC_NONE;
            cmd.mv_en   = 1'b1;
            cmd.mv_dst  = DST_RES;
            cmd.mv_src  = SRC_C;
            state_in    = ST_FIN;
         end
         // detach a child from its parent
         ST_DC0: begin
            if (!status.p_ok) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_PARENT;
               cmd.rd_addr = SRC_P;
               cmd.rd_dst  = DST_A;
               state_in    = ST_DC1;
            end
         end
         ST_DC1: state_in = ST_DC2;
         ST_DC2: begin
            if (status.a_none) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_arr  = ARR_PSIB;
               cmd.rd_addr = SRC_P;
               cmd.rd_dst  = DST_B;
               state_in    = ST_DC3;
            end
         end
         ST_DC3: state_in = ST_DC4;
         ST_DC4: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_arr  = ARR_NSIB;
            cmd.rd_addr = SRC_P;
            cmd.rd_dst  = DST_C;
            state_in    = ST_DC5;
         end
         ST_DC5: state_in = ST_DC6;
         ST_DC6: begin
            cmd.wr_mask = MASK_NSIB;
            cmd.wr_addr = SRC_B;
            cmd.wr_data = SRC_C;
            cmd.rd_en   = 1'b1;
            cmd.rd_arr  = ARR_FCHILD;
            cmd.rd_addr = SRC_A;
            cmd.rd_dst  = DST_D;
            state_in    = ST_DC7;
         end
         ST_DC7: begin
            cmd.wr_mask = MASK_PSIB;
            cmd.wr_addr = SRC_C;
            cmd.wr_data = SRC_B;
            state_in    = ST_DC8;
         end
         ST_DC8: begin
            if (status.d_eq_p) begin
               cmd.wr_mask = MASK_FCHILD;
               cmd.wr_addr = SRC_A;
               cmd.wr_data = SRC_C;
            end
            state_in = ST_DC9;
         end
         ST_DC9: begin
            cmd.wr_mask = MASK_PARENT | MASK_NSIB | MASK_PSIB;
            cmd.wr_addr = SRC_P;
            cmd.wr_data = SRC_NONE;
            cmd.mv_en   = 1'b1;
            cmd.mv_dst  = DST_RES;
            cmd.mv_src  = SRC_P;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (!status.rsp_busy) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         qsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         qsel_ff  <= qsel_in;
      end
   end

endmodule

### hdl/peqm_dpath.sv
// datapath of the entry queue manager: link memories, working registers,
// result register; depends on peqm_pkg and peqm_ram
module peqm_dpath import peqm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [FUNC_W-1:0] req_tuser,
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   input  cmd_type           cmd,
   output status_type        status
);

   logic [FUNC_W-1:0] func_ff, func_in;
   logic [LINK_W-1:0] tl_ff, tl_in;
   logic [LINK_W-1:0] ft_ff, ft_in;
   logic [LINK_W-1:0] p_ff, p_in;
   logic [LINK_W-1:0] par_ff, par_in;
   logic [LINK_W-1:0] res_ff, res_in;
   logic [LINK_W-1:0] a_ff, a_in;
   logic [LINK_W-1:0] b_ff, b_in;
   logic [LINK_W-1:0] c_ff, c_in;
   logic [LINK_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rd_pend_ff;
   arr_type           rd_arr_ff;
   dst_type           rd_dst_ff;
   logic              rd_ok_ff;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   logic [NUM_ARR-1:0][NUM_ENTRIES-1:0] valid_ff;

   logic [RES_W-1:0]  out_res_ff;
   logic [TAIL_W-1:0] out_tail_ff;
   logic              out_found_ff;
   logic              rsp_valid_ff;

   logic [LINK_W-1:0] rd_addr_val, wr_addr_val, wr_data_val, mv_val, rdata;
   logic              rd_inrange, wr_inrange;
   logic [LINK_W-1:0] ram_q [NUM_ARR];
   logic [LINK_W-1:0] tail_raw;

   function automatic logic [LINK_W-1:0] pick(src_type s);
      logic [LINK_W-1:0] v;
      case (s)
         SRC_TL:  v = tl_ff;
         SRC_FT:  v = ft_ff;
         SRC_P:   v = p_ff;
         SRC_PAR: v = par_ff;
         SRC_A:   v = a_ff;
         SRC_B:   v = b_ff;
         SRC_C:   v = c_ff;
         SRC_D:   v = d_ff;
         SRC_RES: v = res_ff;
         default: v = NONE;
      endcase
      return v;
   endfunction

   always_comb begin
      rd_addr_val = pick(cmd.rd_addr);
      wr_addr_val = pick(cmd.wr_addr);
      wr_data_val = pick(cmd.wr_data);
      mv_val      = pick(cmd.mv_src);
   end

   assign rd_inrange  = rd_addr_val < LINK_W'(NUM_ENTRIES);
   assign wr_inrange  = wr_addr_val < LINK_W'(NUM_ENTRIES);

   for (genvar k = 0; k < NUM_ARR; k++) begin : g_arr
      peqm_ram #(
         .WIDTH (LINK_W),
         .DEPTH (NUM_ENTRIES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (cmd.wr_mask[k] && wr_inrange),
         .wr_addr (wr_addr_val[IDX_W-1:0]),
         .wr_data (wr_data_val),
         .rd_en   (cmd.rd_en && (cmd.rd_arr == arr_type'(k))),
         .rd_addr (rd_addr_val[IDX_W-1:0]),
         .rd_data (ram_q[k])
      );
   end

   // out of range reads give none, never written entries give the reset ring
   always_comb begin
      if (!rd_ok_ff) begin
         rdata = NONE;
      end else if (rd_vld_ff) begin
         rdata = ram_q[rd_arr_ff];
      end else begin
         rdata = reset_link(rd_arr_ff, rd_idx_ff);
      end
   end

   assign tail_raw = LINK_W'(req_tdata[TAIL_W-1:0]);

   always_comb begin
      func_in = func_ff;
      tl_in   = tl_ff;
      ft_in   = ft_ff;
      p_in    = p_ff;
      par_in  = par_ff;
      res_in  = res_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      d_in    = d_ff;
      if (rd_pend_ff) begin
         case (rd_dst_ff)
            DST_A:   a_in   = rdata;
            DST_B:   b_in   = rdata;
            DST_C:   c_in   = rdata;
            DST_D:   d_in   = rdata;
            DST_RES: res_in = rdata;
            DST_TL:  tl_in  = rdata;
            DST_FT:  ft_in  = rdata;
            default: ;
         endcase
      end
      if (cmd.mv_en) begin
         case (cmd.mv_dst)
            DST_A:   a_in   = mv_val;
            DST_B:   b_in   = mv_val;
            DST_C:   c_in   = mv_val;
            DST_D:   d_in   = mv_val;
            DST_RES: res_in = mv_val;
            DST_TL:  tl_in  = mv_val;
            DST_FT:  ft_in  = mv_val;
            default: ;
         endcase
      end
      if (cmd.load) begin
         func_in = req_tuser;
         tl_in   = (req_tdata[TAIL_W-1:0] >= TAIL_W'(NUM_ENTRIES)) ? NONE : tail_raw;
         p_in    = LINK_W'(req_tdata[TAIL_W +: ENTRY_W]);
         par_in  = LINK_W'(req_tdata[TAIL_W+ENTRY_W +: ENTRY_W]);
         res_in  = NONE;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      tl_ff   <= tl_in;
      p_ff    <= p_in;
      par_ff  <= par_in;
      res_ff  <= res_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      cnt_ff  <= cnt_in;
      rd_arr_ff <= cmd.rd_arr;
      rd_dst_ff <= cmd.rd_dst;
      rd_ok_ff  <= rd_inrange;
      rd_vld_ff <= valid_ff[cmd.rd_arr][rd_addr_val[IDX_W-1:0]];
      rd_idx_ff <= rd_addr_val[IDX_W-1:0];
      if (cmd.done) begin
         out_res_ff   <= RES_W'(res_ff);
         out_tail_ff  <= TAIL_W'(tl_ff);
         out_found_ff <= res_ff < LINK_W'(NUM_ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ft_ff        <= LINK_W'(NUM_ENTRIES - 1);
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ft_ff      <= ft_in;
         rd_pend_ff <= cmd.rd_en;
         for (int k = 0; k < NUM_ARR; k++) begin
            if (cmd.wr_mask[k] && wr_inrange) begin
               valid_ff[k][wr_addr_val[IDX_W-1:0]] <= 1'b1;
            end
         end
         if (cmd.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_found_ff, out_tail_ff, out_res_ff};

   assign status.func     = func_ff;
   assign status.p_ok     = p_ff < LINK_W'(NUM_ENTRIES);
   assign status.par_ok   = par_ff < LINK_W'(NUM_ENTRIES);
   assign status.tl_none  = tl_ff == NONE;
   assign status.ft_none  = ft_ff == NONE;
   assign status.a_none   = a_ff == NONE;
   assign status.c_none   = c_ff == NONE;
   assign status.a_eq_p   = a_ff == p_ff;
   assign status.a_eq_tl  = a_ff == tl_ff;
   assign status.a_eq_ft  = a_ff == ft_ff;
   assign status.b_eq_p   = b_ff == p_ff;
   assign status.d_eq_p   = d_ff == p_ff;
   assign status.p_eq_tl  = p_ff == tl_ff;
   assign status.cnt_end  = cnt_ff == CNT_W'(NUM_ENTRIES);
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

endmodule

### hdl/process_entry_queue_manager_unit.sv
// Entry queue manager: a pool of entries with circular queue links, a free
// list and parent/child/sibling links, one request per item.
// Request channel req_*: req_tuser holds the request code, req_tdata the
// caller's queue tail, the entry and the parent entry. Result channel
// rsp_*: one item per request with the returned entry, the new tail and
// a found flag. Every request gives exactly one result.
// Items are served one at a time by a sequencer over six link memories,
// each access a read plus a wait for the registered read data.
// Remove named walks the caller queue link by link. req_tready is high
// only between requests.
// A finished result waits in an output register; the next request is taken
// meanwhile, and its result is held back while rsp_tready stays low.
// Reset puts every entry on the free list in index order at once (unwritten
// entries read their reset links through per entry valid bits), clears the
// output valid flag and leaves the block ready.
// depends on peqm_pkg, peqm_ctrl, peqm_dpath
module process_entry_queue_manager_unit import peqm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [FUNC_W-1:0] req_tuser,  // func
   input  logic [REQ_W-1:0]  req_tdata,  // tail_in[5:0], entry[10:6], parent_entry[15:11]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata   // result_entry[5:0], tail_out[11:6], found[12]
);

   cmd_type    cmd;
   status_type status;

   peqm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   peqm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### hdl/peqm_checker.sv
// port level checks of the entry queue manager, bound to the top level
// depends on peqm_pkg and process_entry_queue_manager_unit_macros.svh
`include "process_entry_queue_manager_unit_macros.svh"
module peqm_checker import peqm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [FUNC_W-1:0] req_tuser,
   input logic [REQ_W-1:0]  req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata
);

   `PEQM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   // one item at a time: ready drops right after an accept
   `PEQM_ASSERT(a_one_item, req_tvalid && req_tready |=> !req_tready)
   // found flag agrees with the returned entry
   `PEQM_ASSERT(a_found, rsp_tvalid |-> (rsp_tdata[12] == (rsp_tdata[5:0] != RES_W'(NUM_ENTRIES))))
   `PEQM_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_tvalid)

endmodule

bind process_entry_queue_manager_unit peqm_checker u_peqm_checker (.*);

### tb/tb.sv
// testbench for process_entry_queue_manager_unit: drives requests with bursty
// timing, predicts each result with a local link model and checks it
// depends on peqm_pkg and process_entry_queue_manager_unit
`timescale 1ns / 100ps

module tb;
   import peqm_pkg::*;

   localparam int N = NUM_ENTRIES;
   localparam int LIMIT = 20000;

   // packed from the top bit down: found, tail, result entry
   typedef struct packed {
      logic              found;
      logic [TAIL_W-1:0] tail;
      logic [RES_W-1:0]  res;
   } rsp_item;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [FUNC_W-1:0] req_tuser = '0;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   int nxt [N], prv [N], par [N], fch [N], nsib [N], psib [N];
   int free_tl;
   int queue_tail [4];
   rsp_item expected_rsp [$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;

   process_entry_queue_manager_unit u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int rd(ref int a [N], input int i);
      return (i < N) ? a[i] : N;
   endfunction

   function automatic void wr(ref int a [N], input int i, input int v);
      if (i < N) a[i] = v;
   endfunction

   function automatic int append_link(int tl, int p);
      int head;
      if (tl == N) begin
         wr(nxt, p, p);
         wr(prv, p, p);
      end else begin
         head = rd(nxt, tl);
         wr(nxt, p, head);
         wr(nxt, tl, p);
         wr(prv, p, tl);
         wr(prv, head, p);
      end
      return p;
   endfunction

   function automatic int take_head(ref int tl);
      int head, after;
      if (tl == N) return N;
      head = rd(nxt, tl);
      after = rd(nxt, head);
      wr(nxt, tl, after);
      wr(prv, after, tl);
      if (head == tl) tl = N;
      return head;
   endfunction

   function automatic void clear_tree(int p);
      wr(par, p, N);
      wr(nsib, p, N);
      wr(psib, p, N);
   endfunction

   function automatic void reset_links();
      for (int i = 0; i < N; i++) begin
         nxt[i] = (i + 1) % N;
         prv[i] = (i + N - 1) % N;
         par[i] = N; fch[i] = N; nsib[i] = N; psib[i] = N;
      end
      free_tl = N - 1;
   endfunction

   // computes the result of one request and updates the link model
   function automatic rsp_item serve_request(logic [3:0] fn, int tl, int p, int pe);
      int res, cur, nx, pv, c, pr;
      rsp_item r;
      res = N;
      if (tl >= N) tl = N;
      case (fn)
         FN_ALLOC: begin
            res = take_head(free_tl);
            if (res < N) begin
               wr(nxt, res, N); wr(prv, res, N); wr(fch, res, N);
               clear_tree(res);
            end
         end
         FN_FREE: free_tl = append_link(free_tl, p);
         FN_ENQ: tl = append_link(tl, p);
         FN_DEQ: res = take_head(tl);
         FN_REMOVE: begin
            if (tl != N) begin
               cur = rd(nxt, tl);
               for (int i = 0; i < N && cur != N; i++) begin
                  if (cur == p) begin
                     nx = rd(nxt, p); pv = rd(prv, p);
                     if (p == tl) tl = (nx == p) ? N : pv;
                     if (nx != p) begin
                        wr(prv, nx, pv);
                        wr(nxt, pv, nx);
                     end
                     res = p;
                     break;
                  end
                  if (cur == tl) break;
                  cur = rd(nxt, cur);
               end
            end
         end
         FN_PEEK: if (tl != N) res = rd(nxt, tl);
         FN_ADD_CH: begin
            c = rd(fch, pe);
            wr(nsib, p, c);
            wr(psib, p, N);
            wr(psib, c, p);
            wr(fch, pe, p);
            wr(par, p, pe);
         end
         FN_REM_CH: begin
            c = rd(fch, pe);
            if (c != N) begin
               nx = rd(nsib, c);
               wr(fch, pe, nx);
               wr(psib, nx, N);
               clear_tree(c);
               res = c;
            end
         end
         FN_DETACH: begin
            pr = rd(par, p);
            if (pr != N) begin
               pv = rd(psib, p); nx = rd(nsib, p);
               wr(nsib, pv, nx);
               wr(psib, nx, pv);
               if (rd(fch, pr) == p) wr(fch, pr, nx);
               clear_tree(p);
               res = p;
            end
         end
         default: ;
      endcase
      r.res = RES_W'(res);
      r.tail = TAIL_W'(tl);
      r.found = (res < N);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("error: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // sends one item, tracking the caller queue slot q (-1: raw tail)
   task automatic send_request(logic [3:0] fn, int tl, int p, int pe, int q = -1);
      rsp_item r;
      if (q >= 0) tl = queue_tail[q];
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {5'(pe), 5'(p), 6'(tl)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = serve_request(fn, tl, p, pe);
      expected_rsp.push_back(r);
      if (q >= 0 && fn inside {FN_ENQ, FN_DEQ, FN_REMOVE}) queue_tail[q] = r.tail;
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_item got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_item'(rsp_tdata[12:0]);
         if (expected_rsp.size() == 0) report_mismatch("unexpected item", got, 0);
         else begin
            want = expected_rsp.pop_front();
            if (got.res != want.res) report_mismatch("result_entry", got.res, want.res);
            if (got.tail != want.tail) report_mismatch("tail_out", got.tail, want.tail);
            if (got.found != want.found) report_mismatch("found", got.found, want.found);
         end
      end
      rsp_tready <= hold_off ? 1'b0 : ($urandom_range(0, 9) < 7 || (($urandom & 3) == 0));
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
         $display("process_entry_queue_manager_unit: mismatch");
         $finish;
      end
   end

   task automatic test_directed();
      send_request(FN_PEEK, 63, 0, 0);
      send_request(FN_DEQ, N, 0, 0);
      for (int i = 0; i < 4; i++) send_request(FN_ALLOC, 0, 0, 0);
      send_request(FN_ENQ, 0, 0, 0, 0);
      send_request(FN_ENQ, 0, 1, 0, 0);
      send_request(FN_ENQ, 0, 2, 0, 0);
      send_request(FN_PEEK, 0, 0, 0, 0);
      send_request(FN_REMOVE, 0, 2, 0, 0);
      send_request(FN_REMOVE, 0, 31, 0, 0);
      send_request(FN_REMOVE, 0, 0, 0, 0);
      send_request(FN_DEQ, 0, 0, 0, 0);
      send_request(FN_DEQ, 0, 0, 0, 0);
      send_request(FN_ADD_CH, 0, 1, 0);
      send_request(FN_ADD_CH, 0, 2, 0);
      send_request(FN_ADD_CH, 0, 31, 0);
      send_request(FN_DETACH, 0, 2, 0);
      send_request(FN_REM_CH, 0, 0, 0);
      send_request(FN_REM_CH, 0, 0, 31);
      send_request(FN_DETACH, 0, 3, 0);
      send_request(FN_FREE, 0, 2, 0);
      send_request(4'd15, 33, 31, 31);
      send_request(4'd9, 0, 0, 0);
   endtask

   // mostly consistent use of the pool, some misuse and raw noise
   task automatic test_random(int count);
      int kind, q, e;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 19);
         q = $urandom_range(0, 3);
         e = $urandom_range(0, N - 1);
         if (kind < 3) send_request(FN_ALLOC, $urandom_range(0, 63), e, e);
         else if (kind < 5) send_request(FN_FREE, 0, e, 0);
         else if (kind < 8) send_request(FN_ENQ, 0, e, 0, q);
         else if (kind < 10) send_request(FN_DEQ, 0, 0, 0, q);
         else if (kind < 12) send_request(FN_REMOVE, 0, e, 0, q);
         else if (kind < 13) send_request(FN_PEEK, 0, 0, 0, q);
         else if (kind < 15) send_request(FN_ADD_CH, 0, e, $urandom_range(0, 3));
         else if (kind < 16) send_request(FN_REM_CH, 0, 0, $urandom_range(0, N - 1));
         else if (kind < 18) send_request(FN_DETACH, 0, e, 0);
         else send_request(4'($urandom), $urandom_range(0, 63), e, $urandom_range(0, N - 1));
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(20);
      join
   endtask

   initial begin
      int wait_cycles;
      reset_links();
      for (int i = 0; i < 4; i++) queue_tail[i] = N;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1600);
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (expected_rsp.size() != 0 && wait_cycles < LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("process_entry_queue_manager_unit: match");
      else
         $display("process_entry_queue_manager_unit: mismatch");
      $finish;
   end
endmodule
